[hw/rtl/pfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and the symbol function of the pulse classifier.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int MAX_PULSES_DEF = 256;

  localparam logic [31:0] FNV_START = 32'd2166136261;
  localparam logic [31:0] FNV_MUL   = 32'd16777619;
  localparam logic [7:0]  ODD_MARK  = 8'h10;
  localparam logic [3:0]  SYM_MAX   = 4'd15;
  localparam logic [7:0]  STREAK_MAX = 8'd255;
  localparam logic [6:0]  PCT_FULL  = 7'd100;

  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_GLITCH_FLOOR   = 3'd0,
    REG_GLITCH_CEILING = 3'd1,
    REG_REPEAT_DELTA   = 3'd2,
    REG_FAMILY_DELTA   = 3'd3,
    REG_COUNT_TOL      = 3'd4,
    REG_BASE_TOL_FLOOR = 3'd5,
    REG_ROLLING_MIN    = 3'd6,
    REG_NONE           = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    V_BASELINE  = 3'd0,
    V_REPEATED  = 3'd1,
    V_CHANGED   = 3'd2,
    V_ROLLING   = 3'd3,
    V_DIFFERENT = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [12:0] glitch_floor_us;
    logic [15:0] glitch_ceiling_us;
    logic [6:0]  repeat_delta_pct;
    logic [6:0]  family_delta_pct;
    logic [6:0]  count_tolerance_pct;
    logic [12:0] base_tolerance_floor_us;
    logic [7:0]  rolling_streak_min;
  } cfg_t;

  // round(d / base), held to 1..15
  function automatic logic [3:0] quantize(input logic [15:0] d, input logic [15:0] base);
    logic [20:0] rem;
    logic [20:0] trial;
    logic [3:0]  r;
    rem = 21'(d) + 21'(base >> 1);
    r   = '0;
    if (rem >= (21'(base) << 4)) begin
      r = SYM_MAX;
    end else begin
      for (int j = 3; j >= 0; j--) begin
        trial = 21'(base) << j;
        if (rem >= trial) begin
          rem  = rem - trial;
          r[j] = 1'b1;
        end
      end
    end
    if (r == 4'd0) r = 4'd1;
    return r;
  endfunction

endpackage

[hw/rtl/pfc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pfc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_cfg
// APB register file holding the classifier thresholds.
// ----------------------------------------------------------------------------
module pfc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output pfc_pkg::cfg_t                    cfg
);

  pfc_pkg::reg_idx_t idx;

  assign idx    = pfc_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glitch_floor_us        <= 13'd80;
      cfg.glitch_ceiling_us      <= 16'd5000;
      cfg.repeat_delta_pct       <= 7'd3;
      cfg.family_delta_pct       <= 7'd60;
      cfg.count_tolerance_pct    <= 7'd15;
      cfg.base_tolerance_floor_us <= 13'd100;
      cfg.rolling_streak_min     <= 8'd2;
    end else if (psel && penable && pwrite) begin
      case (idx)
        pfc_pkg::REG_GLITCH_FLOOR:   cfg.glitch_floor_us <= pwdata[12:0];
        pfc_pkg::REG_GLITCH_CEILING: cfg.glitch_ceiling_us <= pwdata[15:0];
        pfc_pkg::REG_REPEAT_DELTA:   cfg.repeat_delta_pct <= pwdata[6:0];
        pfc_pkg::REG_FAMILY_DELTA:   cfg.family_delta_pct <= pwdata[6:0];
        pfc_pkg::REG_COUNT_TOL:      cfg.count_tolerance_pct <= pwdata[6:0];
        pfc_pkg::REG_BASE_TOL_FLOOR: cfg.base_tolerance_floor_us <= pwdata[12:0];
        pfc_pkg::REG_ROLLING_MIN:    cfg.rolling_streak_min <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pfc_pkg::REG_GLITCH_FLOOR:   prdata = 32'(cfg.glitch_floor_us);
      pfc_pkg::REG_GLITCH_CEILING: prdata = 32'(cfg.glitch_ceiling_us);
      pfc_pkg::REG_REPEAT_DELTA:   prdata = 32'(cfg.repeat_delta_pct);
      pfc_pkg::REG_FAMILY_DELTA:   prdata = 32'(cfg.family_delta_pct);
      pfc_pkg::REG_COUNT_TOL:      prdata = 32'(cfg.count_tolerance_pct);
      pfc_pkg::REG_BASE_TOL_FLOOR: prdata = 32'(cfg.base_tolerance_floor_us);
      pfc_pkg::REG_ROLLING_MIN:    prdata = 32'(cfg.rolling_streak_min);
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/pfc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_div
// Restoring divider for the difference percentage, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pfc_div #(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW+6:0] num,
  input  logic [CW-1:0] den,
  output logic          done,
  output logic [6:0]    quo
);

  logic [CW+6:0] rem;
  logic [CW+6:0] trial;
  logic [2:0]    step;
  logic          run;

  assign trial = (CW+7)'(den) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= num;
        step <= 3'd6;
        quo  <= '0;
      end else if (run) begin
        // quotient is known to fit in seven bits
        if (rem >= trial) begin
          rem       <= rem - trial;
          quo[step] <= 1'b1;
        end
        if (step == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

endmodule

[hw/rtl/pulse_fingerprint_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_fingerprint_classifier_top
// Burst fingerprinting: base pulse, symbol hash, verdict against prior burst.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, pulse_duration, last_pulse) takes one
//   duration word a cycle while the block is loading; words past MAX_PULSES
//   are dropped, and last_pulse ends the burst.
//   After the last word the block raises in_stall and works through the
//   duration RAM: one counting pass and sixteen radix passes to select the
//   base (skipped when no duration qualifies), then states S_QREAD, S_QCALC
//   and S_QHASH on each pulse for symbols, hash and prior compare, the count
//   hash, a percentage divide and the output state.
//   One result word per burst leaves on out_valid/out_stall. It is held in an
//   output register, so the next burst loads while it waits; a finished burst
//   waits for that register to empty.
//   Configuration: APB, register i at byte 4*i, to be written by the user
//   only while idle; the block does not enforce it. Reset (rst, synchronous)
//   restores defaults, empties the burst, forgets prior burst and counters.
// ----------------------------------------------------------------------------
module pulse_fingerprint_classifier_top #(
  parameter int MAX_PULSES = pfc_pkg::MAX_PULSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    pulse_duration,
  input  logic                           last_pulse,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     verdict,
  output logic [31:0]                    signature,
  output logic [8:0]                     pulse_total,
  output logic [15:0]                    base_pulse_us,
  output logic [6:0]                     symbol_diff_pct,
  output logic [31:0]                    bursts_seen,
  output logic [31:0]                    unique_seen,
  output logic [31:0]                    repeats_seen,
  output logic [31:0]                    changes_seen,
  output logic [7:0]                     change_streak
);

  localparam int CW = $clog2(MAX_PULSES + 1);
  localparam int AW = $clog2(MAX_PULSES);
  localparam logic [6:0] PCT_FULL_C = pfc_pkg::PCT_FULL;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SELECT, S_QREAD, S_QCALC, S_QHASH,
    S_CNTHASH, S_DIV_START, S_DIV_WAIT, S_OUT
  } state_t;

  pfc_pkg::cfg_t cfg;
  state_t        state;

  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic          rv;
  logic          pass0;
  logic [3:0]    bitpos;
  logic [CW-1:0] acc;
  logic [CW-1:0] kth;
  logic [15:0]   prefix;
  logic [15:0]   base;
  logic [3:0]    sym;
  logic [31:0]   hash;
  logic [CW-1:0] diff;
  logic [6:0]    delta;

  logic [CW-1:0] prior_count;
  logic [15:0]   prior_base;
  logic [31:0]   prior_hash;
  logic          have_prior;
  logic [31:0]   burst_cnt, unique_cnt, repeat_cnt, change_cnt;
  logic [7:0]    streak;

  logic          dur_we;
  logic [15:0]   dur_rdata;
  logic [3:0]    pri_rdata;
  logic          accept;
  logic          qual;
  logic          match;
  logic [16:0]   hi_mask;
  logic [CW-1:0] maxc, minc;
  logic [31:0]   hash_in;
  logic [31:0]   hash_mix;
  logic [7:0]    sym_byte;
  logic          div_done;
  logic [6:0]    div_quo;
  logic [CW+6:0] div_num;
  logic [15:0]   base_sel;

  pfc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign dur_we = accept && (fill < CW'(MAX_PULSES));

  pfc_ram #(.WIDTH(16), .DEPTH(MAX_PULSES)) u_dur_ram (
    .clk, .we(dur_we), .waddr(fill[AW-1:0]), .wdata(pulse_duration),
    .raddr(idx[AW-1:0]), .rdata(dur_rdata)
  );

  pfc_ram #(.WIDTH(4), .DEPTH(MAX_PULSES)) u_prior_ram (
    .clk, .we(state == S_QHASH), .waddr(idx[AW-1:0]), .wdata(sym),
    .raddr(idx[AW-1:0]), .rdata(pri_rdata)
  );

  assign div_num = (CW+7)'(diff) * (CW+7)'(PCT_FULL_C);

  pfc_div #(.CW(CW)) u_div (
    .clk, .rst, .start(state == S_DIV_START), .num(div_num), .den(maxc),
    .done(div_done), .quo(div_quo)
  );

  assign qual = (dur_rdata >= 16'(cfg.glitch_floor_us)) &&
                (dur_rdata <= cfg.glitch_ceiling_us);
  assign hi_mask = 17'h1FFFF << (5'(bitpos) + 5'd1);
  assign match = (((dur_rdata ^ prefix) & hi_mask[15:0]) == 16'd0) && !dur_rdata[bitpos];

  assign maxc = (fill > prior_count) ? fill : prior_count;
  assign minc = (fill < prior_count) ? fill : prior_count;

  assign sym_byte = 8'(sym) | (idx[0] ? pfc_pkg::ODD_MARK : 8'h00);
  assign hash_in  = (state == S_CNTHASH) ? 32'(fill) : 32'(sym_byte);
  assign hash_mix = hash ^ hash_in;

  // base chosen from a finished selection, or the glitch floor when none qualified; zero raised to one
  always_comb begin
    base_sel = pass0 ? 16'(cfg.glitch_floor_us)
                     : ((kth < acc) ? prefix : (prefix | (16'd1 << bitpos)));
    if (base_sel == 16'd0) base_sel = 16'd1;
  end

  // verdict and family test
  logic [CW-1:0] cnt_gap;
  logic [15:0]   base_dist;
  logic [15:0]   tol;
  logic [32:0]   third;
  logic          family;
  logic          repeated;
  logic [7:0]    streak_up;
  logic [31:0]   cnt32;

  assign cnt_gap  = maxc - minc;
  assign base_dist = (base > prior_base) ? base - prior_base : prior_base - base;
  assign third    = (33'(prior_base) * 33'd43691) >> 17;
  assign tol      = (third[15:0] < 16'(cfg.base_tolerance_floor_us)) ?
                    16'(cfg.base_tolerance_floor_us) : third[15:0];
  assign family   = ((CW+7)'(cnt_gap) * (CW+7)'(PCT_FULL_C) <=
                     (CW+7)'(maxc) * (CW+7)'(cfg.count_tolerance_pct)) &&
                    (base_dist <= tol);
  assign repeated = (hash == prior_hash) || (delta <= cfg.repeat_delta_pct);
  assign streak_up = (streak < pfc_pkg::STREAK_MAX) ? streak + 8'd1 : streak;
  assign cnt32 = 32'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      rv          <= 1'b0;
      out_valid   <= 1'b0;
      prior_count <= '0;
      prior_base  <= '0;
      prior_hash  <= '0;
      have_prior  <= 1'b0;
      burst_cnt   <= '0;
      unique_cnt  <= '0;
      repeat_cnt  <= '0;
      change_cnt  <= '0;
      streak      <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (fill < CW'(MAX_PULSES)) fill <= fill + CW'(1);
            if (last_pulse) begin
              state <= S_SCAN;
              pass0 <= 1'b1;
              idx   <= '0;
              acc   <= '0;
              rv    <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // stream reads, count one word behind the address
          if (idx != fill) begin
            idx <= idx + CW'(1);
            rv  <= 1'b1;
          end else begin
            rv  <= 1'b0;
          end
          if (rv && qual && (pass0 || match)) acc <= acc + CW'(1);
          if (idx == fill && !rv) state <= S_SELECT;
        end
        S_SELECT: begin
          idx <= '0;
          acc <= '0;
          if (pass0 && acc != '0) begin
            pass0  <= 1'b0;
            kth    <= acc >> 3;
            bitpos <= 4'd15;
            prefix <= '0;
            state  <= S_SCAN;
          end else if (!pass0 && bitpos != 4'd0) begin
            if (kth >= acc) begin
              kth    <= kth - acc;
              prefix <= prefix | (16'd1 << bitpos);
            end
            bitpos <= bitpos - 4'd1;
            state  <= S_SCAN;
          end else begin
            base  <= base_sel;
            hash  <= pfc_pkg::FNV_START;
            diff  <= maxc - minc;
            state <= S_QREAD;
          end
        end
        S_QREAD: state <= S_QCALC;
        S_QCALC: begin
          sym   <= pfc_pkg::quantize(dur_rdata, base);
          state <= S_QHASH;
        end
        S_QHASH: begin
          hash <= hash_mix * pfc_pkg::FNV_MUL;
          if (idx < minc && sym != pri_rdata) diff <= diff + CW'(1);
          idx <= idx + CW'(1);
          state <= (idx + CW'(1) == fill) ? S_CNTHASH : S_QREAD;
        end
        S_CNTHASH: begin
          hash  <= hash_mix * pfc_pkg::FNV_MUL;
          state <= S_DIV_START;
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            delta <= !have_prior ? 7'd0 :
                     ((div_quo > PCT_FULL_C) ? PCT_FULL_C : div_quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            signature       <= hash;
            pulse_total     <= cnt32[8:0];
            base_pulse_us   <= base;
            symbol_diff_pct <= delta;
            bursts_seen     <= burst_cnt + 32'd1;
            burst_cnt       <= burst_cnt + 32'd1;
            unique_seen     <= unique_cnt;
            repeats_seen    <= repeat_cnt;
            changes_seen    <= change_cnt;
            change_streak   <= 8'd0;
            streak          <= 8'd0;
            if (!have_prior) begin
              verdict     <= pfc_pkg::V_BASELINE;
              unique_cnt  <= unique_cnt + 32'd1;
              unique_seen <= unique_cnt + 32'd1;
            end else if (repeated) begin
              verdict      <= pfc_pkg::V_REPEATED;
              repeat_cnt   <= repeat_cnt + 32'd1;
              repeats_seen <= repeat_cnt + 32'd1;
            end else if (family && delta <= cfg.family_delta_pct) begin
              verdict       <= (streak_up >= cfg.rolling_streak_min) ?
                               pfc_pkg::V_ROLLING : pfc_pkg::V_CHANGED;
              unique_cnt    <= unique_cnt + 32'd1;
              unique_seen   <= unique_cnt + 32'd1;
              change_cnt    <= change_cnt + 32'd1;
              changes_seen  <= change_cnt + 32'd1;
              streak        <= streak_up;
              change_streak <= streak_up;
            end else begin
              verdict     <= pfc_pkg::V_DIFFERENT;
              unique_cnt  <= unique_cnt + 32'd1;
              unique_seen <= unique_cnt + 32'd1;
            end
            prior_count <= fill;
            prior_base  <= base;
            prior_hash  <= hash;
            have_prior  <= 1'b1;
            fill        <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_PULSES)) else $error("fill count past capacity");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !dur_we) else $error("duration write while busy");
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result without finish");
  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (symbol_diff_pct <= pfc_pkg::PCT_FULL &&
                   verdict <= pfc_pkg::V_DIFFERENT)) else $error("result out of range");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse fingerprint classifier testbench
// Feeds pulse bursts with random idling on both channels, predicts base pulse,
// signature, verdict and counters per burst, and checks every result word in
// order. Registers are reprogrammed over APB between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAXP = 256;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] signature;
    logic [8:0]  pulse_total;
    logic [15:0] base_pulse_us;
    logic [6:0]  symbol_diff_pct;
    logic [31:0] bursts_seen;
    logic [31:0] unique_seen;
    logic [31:0] repeats_seen;
    logic [31:0] changes_seen;
    logic [7:0]  change_streak;
  } burst_result_t;

  class burst_scoreboard;
    int unsigned floor_us = 80, ceil_us = 5000, rep_pct = 3, fam_pct = 60;
    int unsigned cnt_tol = 15, base_tol = 100, roll_min = 2;
    logic [15:0] store[MAXP];
    int unsigned fill;
    logic [3:0] prior_sym[MAXP];
    int unsigned prior_cnt, prior_base;
    logic [31:0] prior_sig;
    bit have_prior;
    logic [31:0] n_burst = '0, n_uniq = '0, n_rep = '0, n_chg = '0;
    int unsigned streak;
    burst_result_t pending[$];
    int errors, results;
    int verdict_hits[5];

    function void set_reg(pfc_pkg::reg_idx_t r, int unsigned v);
      case (r)
        pfc_pkg::REG_GLITCH_FLOOR:   floor_us = v & 16'h1FFF;
        pfc_pkg::REG_GLITCH_CEILING: ceil_us = v & 16'hFFFF;
        pfc_pkg::REG_REPEAT_DELTA:   rep_pct = v & 7'h7F;
        pfc_pkg::REG_FAMILY_DELTA:   fam_pct = v & 7'h7F;
        pfc_pkg::REG_COUNT_TOL:      cnt_tol = v & 7'h7F;
        pfc_pkg::REG_BASE_TOL_FLOOR: base_tol = v & 16'h1FFF;
        pfc_pkg::REG_ROLLING_MIN:    roll_min = v & 8'hFF;
        default: ;
      endcase
    endfunction

    function void note_word(logic [15:0] d, logic last);
      int unsigned sel[$];
      int unsigned base, r, diff, delta, maxc, minc, tol, gapc, gapb;
      logic [31:0] h;
      logic [3:0] sym[MAXP];
      bit fam;
      burst_result_t e;
      if (fill < MAXP) begin
        store[fill] = d;
        fill++;
      end
      if (!last) return;
      for (int i = 0; i < fill; i++)
        if (store[i] >= floor_us && store[i] <= ceil_us) sel.push_back(32'(store[i]));
      if (sel.size() == 0) base = floor_us;
      else begin
        sel.sort();
        base = sel[sel.size() / 8];
      end
      if (base == 0) base = 1;
      h = pfc_pkg::FNV_START;
      for (int i = 0; i < fill; i++) begin
        r = (store[i] + base / 2) / base;
        if (r < 1) r = 1;
        if (r > 15) r = 15;
        sym[i] = 4'(r);
        h = (h ^ (r | ((i & 1) ? 32'h10 : 32'h0))) * pfc_pkg::FNV_MUL;
      end
      h = (h ^ fill) * pfc_pkg::FNV_MUL;
      n_burst++;
      maxc = fill > prior_cnt ? fill : prior_cnt;
      minc = fill < prior_cnt ? fill : prior_cnt;
      delta = 0;
      if (have_prior && maxc > 0) begin
        diff = maxc - minc;
        for (int i = 0; i < minc; i++) if (sym[i] != prior_sym[i]) diff++;
        delta = diff * 100 / maxc;
        if (delta > 100) delta = 100;
      end
      if (!have_prior) begin
        e.verdict = pfc_pkg::V_BASELINE; n_uniq++; streak = 0;
      end else if (h == prior_sig || delta <= rep_pct) begin
        e.verdict = pfc_pkg::V_REPEATED; n_rep++; streak = 0;
      end else begin
        tol = prior_base / 3;
        if (tol < base_tol) tol = base_tol;
        gapc = maxc - minc;
        gapb = base > prior_base ? base - prior_base : prior_base - base;
        fam = maxc > 0 && gapc * 100 <= maxc * cnt_tol && gapb <= tol;
        if (fam && delta <= fam_pct) begin
          n_uniq++; n_chg++;
          if (streak < 255) streak++;
          e.verdict = streak >= roll_min ? pfc_pkg::V_ROLLING : pfc_pkg::V_CHANGED;
        end else begin
          e.verdict = pfc_pkg::V_DIFFERENT; n_uniq++; streak = 0;
        end
      end
      for (int i = 0; i < fill; i++) prior_sym[i] = sym[i];
      prior_cnt = fill;
      prior_base = base & 16'hFFFF;
      prior_sig = h;
      have_prior = 1;
      e.signature = h; e.pulse_total = fill[8:0]; e.base_pulse_us = base[15:0];
      e.symbol_diff_pct = delta[6:0]; e.bursts_seen = n_burst; e.unique_seen = n_uniq;
      e.repeats_seen = n_rep; e.changes_seen = n_chg; e.change_streak = streak[7:0];
      fill = 0;
      pending.push_back(e);
    endfunction

    function void check_word(burst_result_t a);
      burst_result_t e;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: verdict %0d", a.verdict);
        return;
      end
      e = pending.pop_front();
      if (e.verdict < 5) verdict_hits[e.verdict]++;
      if (a != e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch burst %0d: exp v%0d sig %h n%0d b%0d d%0d c%0d/%0d/%0d/%0d s%0d",
                   e.bursts_seen, e.verdict, e.signature, e.pulse_total, e.base_pulse_us,
                   e.symbol_diff_pct, e.bursts_seen, e.unique_seen, e.repeats_seen,
                   e.changes_seen, e.change_streak,
                   "\n              got v%0d sig %h n%0d b%0d d%0d c%0d/%0d/%0d/%0d s%0d",
                   a.verdict, a.signature, a.pulse_total, a.base_pulse_us,
                   a.symbol_diff_pct, a.bursts_seen, a.unique_seen, a.repeats_seen,
                   a.changes_seen, a.change_streak);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [pfc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, last_pulse = 0, out_valid, out_stall = 0;
  logic [15:0] pulse_duration = '0;
  logic [2:0] verdict;
  logic [31:0] signature, bursts_seen, unique_seen, repeats_seen, changes_seen;
  logic [8:0] pulse_total;
  logic [15:0] base_pulse_us;
  logic [6:0] symbol_diff_pct;
  logic [7:0] change_streak;

  burst_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit calm = 0;
  int words_sent = 0;

  pulse_fingerprint_classifier_top DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("pulse_fingerprint_classifier_top regression: fail");
      $finish;
    end
  end

  // receiver: check accepted words, stall in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_word('{verdict, signature, pulse_total, base_pulse_us, symbol_diff_pct,
                        bursts_seen, unique_seen, repeats_seen, changes_seen,
                        change_streak});
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
      out_stall <= (stall_left > 0);
    end
  end

  task automatic cfg_write(pfc_pkg::reg_idx_t r, int unsigned v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= pfc_pkg::CFG_ADDR_W'(4 * r); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(r, v);
  endtask

  // valid stays up after an accepted word until the next word replaces it or an idle drops it
  task automatic send_word(logic [15:0] d, logic last);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1; pulse_duration <= d; last_pulse <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(d, last);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20 * MAXP + 100) @(posedge clk);
  endtask

  // burst around a base unit, symbols drawn from a template with some noise
  logic [3:0] tmpl[MAXP];
  int tmpl_len = 12;
  task automatic send_burst(int n, int unsigned unit, int flips);
    int k;
    for (int i = 0; i < n; i++) begin
      k = (i < MAXP) ? tmpl[i] : 1;
      if (flips > 0 && $urandom_range(0, 99) < flips) k = $urandom_range(1, 15);
      send_word(16'(k * unit + $urandom_range(0, unit / 4)), i == n - 1);
    end
  endtask

  function automatic void new_template();
    for (int i = 0; i < MAXP; i++) tmpl[i] = 4'($urandom_range(1, 4));
  endfunction

  initial begin
    int n;
    int unsigned unit;
    repeat (5) @(posedge clk);
    rst <= 0;
    new_template();
    // directed: single pulse, extremes, repeats
    send_word(16'd0, 1);
    send_word(16'hFFFF, 0); send_word(16'd0, 0); send_word(16'd400, 1);
    send_word(16'hFFFF, 0); send_word(16'd0, 0); send_word(16'd400, 1);
    send_burst(8, 300, 0);
    send_burst(8, 300, 30);
    send_burst(8, 300, 30);
    drain();
    // zero floor with zero durations, floor above ceiling, extreme settings
    cfg_write(pfc_pkg::REG_GLITCH_FLOOR, 0);
    cfg_write(pfc_pkg::REG_GLITCH_CEILING, 65535);
    cfg_write(pfc_pkg::REG_ROLLING_MIN, 1);
    cfg_write(pfc_pkg::REG_NONE, 32'hFFFF);
    send_word(16'd0, 0); send_word(16'd0, 0); send_word(16'd5, 1);
    drain();
    cfg_write(pfc_pkg::REG_GLITCH_FLOOR, 5000);
    cfg_write(pfc_pkg::REG_GLITCH_CEILING, 1);
    cfg_write(pfc_pkg::REG_REPEAT_DELTA, 0);
    cfg_write(pfc_pkg::REG_FAMILY_DELTA, 100);
    cfg_write(pfc_pkg::REG_COUNT_TOL, 100);
    cfg_write(pfc_pkg::REG_BASE_TOL_FLOOR, 5000);
    send_burst(4, 900, 50);
    send_burst(5, 900, 50);
    send_burst(300, 100, 0); // overflow, last flag on a dropped word
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          cfg_write(pfc_pkg::REG_GLITCH_FLOOR, 80);
          cfg_write(pfc_pkg::REG_GLITCH_CEILING, 5000);
          cfg_write(pfc_pkg::REG_REPEAT_DELTA, 3);
          cfg_write(pfc_pkg::REG_FAMILY_DELTA, 60);
          cfg_write(pfc_pkg::REG_COUNT_TOL, 15);
          cfg_write(pfc_pkg::REG_BASE_TOL_FLOOR, 100);
          cfg_write(pfc_pkg::REG_ROLLING_MIN, 2);
        end
        1: begin
          cfg_write(pfc_pkg::REG_REPEAT_DELTA, 100);
          cfg_write(pfc_pkg::REG_ROLLING_MIN, 255);
          cfg_write(pfc_pkg::REG_COUNT_TOL, 0);
          cfg_write(pfc_pkg::REG_BASE_TOL_FLOOR, 0);
        end
        2: begin
          cfg_write(pfc_pkg::REG_GLITCH_FLOOR, 1);
          cfg_write(pfc_pkg::REG_GLITCH_CEILING, 65535);
          cfg_write(pfc_pkg::REG_REPEAT_DELTA, 10);
          cfg_write(pfc_pkg::REG_FAMILY_DELTA, 0);
          cfg_write(pfc_pkg::REG_COUNT_TOL, 50);
          cfg_write(pfc_pkg::REG_ROLLING_MIN, 3);
        end
        default: begin
          calm = 1;
          cfg_write(pfc_pkg::REG_GLITCH_FLOOR, $urandom_range(1, 300));
          cfg_write(pfc_pkg::REG_GLITCH_CEILING, $urandom_range(2000, 65535));
          cfg_write(pfc_pkg::REG_FAMILY_DELTA, 60);
          cfg_write(pfc_pkg::REG_REPEAT_DELTA, 3);
          cfg_write(pfc_pkg::REG_BASE_TOL_FLOOR, 100);
        end
      endcase
      for (int b = 0; b < 14; b++) begin
        if ($urandom_range(0, 9) == 0) new_template();
        n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(4, 8);
        unit = $urandom_range(0, 7) == 0 ? $urandom_range(1, 4000) : 250;
        if ($urandom_range(0, 9) == 0) begin
          for (int i = 0; i < n; i++) send_word(16'($urandom), i == n - 1);
        end else send_burst(n, unit, $urandom_range(0, 3) == 0 ? 0 : 20);
        if (b == 10) begin
          in_valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    $display("Sent %0d words over %0d bursts; verdicts baseline/rep/chg/roll/diff:",
             words_sent, sb.results);
    $display("  %0d/%0d/%0d/%0d/%0d", sb.verdict_hits[0], sb.verdict_hits[1],
             sb.verdict_hits[2], sb.verdict_hits[3], sb.verdict_hits[4]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("pulse_fingerprint_classifier_top regression: pass");
    else
      $display("pulse_fingerprint_classifier_top regression: fail");
    $finish;
  end
endmodule
